@@ rtl/rpq_pkg.sv @@
// Shared types, constants and codes for the RDOQ pre-quantization block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package rpq_pkg;

	// Coefficient group geometry
	localparam int GROUP_SIZE = 16;
	localparam int GROUP_W    = $clog2(GROUP_SIZE);

	// Defaults for top-level parameters
	localparam int DEF_MAX_COEFFS = 4096;
	localparam int DEF_ERR_SHIFT  = 20;

	// Field widths
	localparam int COEF_W  = 16;
	localparam int MAG_W   = COEF_W + 1;
	localparam int WORD_W  = 32;
	localparam int ERR_W   = 64;
	localparam int IDX_W   = 13;
	localparam int SCALE_W = 16;
	localparam int SHIFT_W = 5;
	localparam int HALF_W  = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SCALE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_QUANT_SHIFT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ERROR_SCALE = 2'd2;

	// Register reset values
	localparam logic [SCALE_W-1:0]    RST_QUANT_SCALE = 16'd1;
	localparam logic [SHIFT_W-1:0]    RST_QUANT_SHIFT = 5'd15;
	localparam logic [CFG_DATA_W-1:0] RST_ERROR_SCALE = 32'd0;

	// Controller states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_ERR,
		ST_SQR,
		ST_OUT
	} rpq_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load_in;
		logic do_s1;
		logic do_s2;
		logic do_s3;
		logic load_out;
	} rpq_cmd_t;

endpackage

@@ rtl/rpq_if.sv @@
// Valid/ready channel interfaces for coefficient input and result output.
// Depends on rpq_pkg for field widths.
`timescale 1ns / 1ps

interface rpq_in_if;
	import rpq_pkg::*;
	logic                     valid;
	logic                     ready;
	logic signed [COEF_W-1:0] coefficient;
	logic                     is_last;

	modport source (output valid, coefficient, is_last, input ready);
	modport sink   (input valid, coefficient, is_last, output ready);
endinterface

interface rpq_out_if;
	import rpq_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [WORD_W-1:0]       scaled_magnitude;
	logic [WORD_W-1:0]       level;
	logic [ERR_W-1:0]        uncoded_error;
	logic                    block_done;
	logic signed [IDX_W-1:0] last_nonzero_index;

	modport source (output valid, scaled_magnitude, level, uncoded_error, block_done,
		last_nonzero_index, input ready);
	modport sink   (input valid, scaled_magnitude, level, uncoded_error, block_done,
		last_nonzero_index, output ready);
endinterface

@@ rtl/rpq_ctrl.sv @@
// Controller FSM: sequences one word through the multiplier chain.
// Depends on rpq_pkg (state enum, command struct).
`timescale 1ns / 1ps

module rpq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	output rpq_pkg::rpq_cmd_t cmd
);
	import rpq_pkg::*;

	rpq_state_t state_q, state_n;
	logic       out_valid_q;

	// Next state
	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_n = ST_MUL;
			ST_MUL:  state_n = ST_ERR;
			ST_ERR:  state_n = ST_SQR;
			ST_SQR:  state_n = ST_OUT;
			ST_OUT:  if (!out_valid_q || out_ready) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	// Outputs and datapath commands
	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_MUL:  cmd.do_s1 = 1'b1;
			ST_ERR:  cmd.do_s2 = 1'b1;
			ST_SQR:  cmd.do_s3 = 1'b1;
			ST_OUT:  cmd.load_out = !out_valid_q || out_ready;
			default: cmd = '0;
		endcase
	end

	assign out_valid = out_valid_q;

	// State and output word valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/rpq_dp.sv @@
// Datapath: config registers, quantizer multiplier chain, last-position tracker.
// Depends on rpq_pkg; driven by commands from rpq_ctrl.
`timescale 1ns / 1ps

module rpq_dp #(
	parameter int MAX_COEFFS = rpq_pkg::DEF_MAX_COEFFS,
	parameter int ERR_SHIFT  = rpq_pkg::DEF_ERR_SHIFT
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  rpq_pkg::rpq_cmd_t                 cmd,
	input  logic                              cfg_wr_en,
	input  logic [rpq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rpq_pkg::CFG_DATA_W-1:0]    cfg_data,
	input  logic signed [rpq_pkg::COEF_W-1:0] coefficient,
	input  logic                              is_last,
	output logic [rpq_pkg::WORD_W-1:0]        scaled_magnitude,
	output logic [rpq_pkg::WORD_W-1:0]        level,
	output logic [rpq_pkg::ERR_W-1:0]         uncoded_error,
	output logic                              block_done,
	output logic signed [rpq_pkg::IDX_W-1:0]  last_nonzero_index
);
	import rpq_pkg::*;

	localparam int POS_W = $clog2(MAX_COEFFS);
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_COEFFS - 1);
	localparam logic [POS_W-1:0] GRP_MASK = POS_W'(GROUP_SIZE - 1);

	// Configuration registers
	logic [SCALE_W-1:0]    quant_scale_q;
	logic [SHIFT_W-1:0]    quant_shift_q;
	logic [CFG_DATA_W-1:0] error_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quant_scale_q <= RST_QUANT_SCALE;
			quant_shift_q <= RST_QUANT_SHIFT;
			error_scale_q <= RST_ERROR_SCALE;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_QUANT_SCALE: quant_scale_q <= cfg_data[SCALE_W-1:0];
				CFG_QUANT_SHIFT: quant_shift_q <= cfg_data[SHIFT_W-1:0];
				CFG_ERROR_SCALE: error_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Rounding offset; hit test is scaled >= max(half, 1), which equals mag >= threshold
	logic [HALF_W-1:0] half_w, thr_min_w;
	assign half_w    = (quant_shift_q == '0) ? '0 : (HALF_W'(1) << (quant_shift_q - 5'd1));
	assign thr_min_w = (half_w == '0) ? HALF_W'(1) : half_w;

	// Input capture
	logic signed [COEF_W-1:0] coef_s1;
	logic                     last_s1;
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			coef_s1 <= coefficient;
			last_s1 <= is_last;
		end
	end

	// Stage 1: magnitude times quant scale (fits 32 bits), hit test
	logic [MAG_W-1:0]    mag_w;
	logic [WORD_W-1:0]   prod1_w;
	logic                hit_w;
	logic [WORD_W-1:0]   scaled_s2;
	logic                hit_s2;

	assign mag_w   = coef_s1[COEF_W-1] ? (MAG_W'(1 << COEF_W) - {1'b0, coef_s1})
	                                   : {1'b0, coef_s1};
	assign prod1_w = WORD_W'(mag_w) * WORD_W'(quant_scale_q);
	assign hit_w   = prod1_w >= {1'b0, thr_min_w};

	always_ff @(posedge clk) begin
		if (cmd.do_s1) begin
			scaled_s2 <= hit_w ? prod1_w : '0;
			hit_s2    <= hit_w;
		end
	end

	// Stage 2: rounded level and distortion word (zero scaled gives zero for both)
	logic [WORD_W:0]     sum_w;
	logic [ERR_W-1:0]    prod2_w;
	logic [WORD_W-1:0]   level_s3;
	logic [WORD_W-1:0]   err_word_s3;

	assign sum_w   = {1'b0, scaled_s2} + (WORD_W+1)'(half_w);
	assign prod2_w = {32'b0, scaled_s2} * {32'b0, error_scale_q};

	always_ff @(posedge clk) begin
		if (cmd.do_s2) begin
			level_s3    <= WORD_W'(sum_w >> quant_shift_q);
			err_word_s3 <= prod2_w[ERR_SHIFT +: WORD_W];
		end
	end

	// Stage 3: square of the distortion word
	logic [ERR_W-1:0] err_sq_s4;
	always_ff @(posedge clk) begin
		if (cmd.do_s3) begin
			err_sq_s4 <= {32'b0, err_word_s3} * {32'b0, err_word_s3};
		end
	end

	// Last-position tracker state
	logic [POS_W-1:0] pos_q;
	logic             cur_hit_q, cur_best_vld_q;
	logic [POS_W-1:0] cur_best_q;
	logic             lhg_vld_q, lhg_best_vld_q;
	logic [POS_W-1:0] lhg_start_q, lhg_best_q;

	logic             cur_hit_n, cur_best_vld_n;
	logic [POS_W-1:0] cur_best_n;
	logic             lhg_vld_n, lhg_best_vld_n;
	logic [POS_W-1:0] lhg_start_n, lhg_best_n;
	logic             close_w;
	logic [IDX_W-1:0] result_idx_w;

	// Group update for the word being retired
	always_comb begin
		cur_hit_n      = cur_hit_q | hit_s2;
		cur_best_vld_n = cur_best_vld_q;
		cur_best_n     = cur_best_q;
		if (hit_s2 && (level_s3 != '0)) begin
			cur_best_vld_n = 1'b1;
			cur_best_n     = pos_q;
		end
		close_w = (pos_q[GROUP_W-1:0] == {GROUP_W{1'b1}}) || (pos_q == POS_LAST) || last_s1;
		lhg_vld_n      = lhg_vld_q;
		lhg_start_n    = lhg_start_q;
		lhg_best_vld_n = lhg_best_vld_q;
		lhg_best_n     = lhg_best_q;
		if (close_w && cur_hit_n) begin
			lhg_vld_n      = 1'b1;
			lhg_start_n    = pos_q & ~GRP_MASK;
			lhg_best_vld_n = cur_best_vld_n;
			lhg_best_n     = cur_best_n;
		end
		// Last word: best index in last hit group, else its start, else -1
		if (!last_s1) begin
			result_idx_w = '0;
		end else if (!lhg_vld_n) begin
			result_idx_w = '1;
		end else if (lhg_best_vld_n) begin
			result_idx_w = IDX_W'(lhg_best_n);
		end else begin
			result_idx_w = IDX_W'(lhg_start_n);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q          <= '0;
			cur_hit_q      <= 1'b0;
			cur_best_vld_q <= 1'b0;
			cur_best_q     <= '0;
			lhg_vld_q      <= 1'b0;
			lhg_best_vld_q <= 1'b0;
			lhg_start_q    <= '0;
			lhg_best_q     <= '0;
		end else if (cmd.load_out) begin
			if (last_s1) begin
				// block finished: back to reset state
				pos_q          <= '0;
				cur_hit_q      <= 1'b0;
				cur_best_vld_q <= 1'b0;
				lhg_vld_q      <= 1'b0;
				lhg_best_vld_q <= 1'b0;
			end else begin
				pos_q          <= (pos_q == POS_LAST) ? '0 : pos_q + 1'b1;
				cur_hit_q      <= close_w ? 1'b0 : cur_hit_n;
				cur_best_vld_q <= close_w ? 1'b0 : cur_best_vld_n;
				cur_best_q     <= cur_best_n;
				lhg_vld_q      <= lhg_vld_n;
				lhg_best_vld_q <= lhg_best_vld_n;
				lhg_start_q    <= lhg_start_n;
				lhg_best_q     <= lhg_best_n;
			end
		end
	end

	// Output word register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			scaled_magnitude   <= scaled_s2;
			level              <= level_s3;
			uncoded_error      <= err_sq_s4;
			block_done         <= last_s1;
			last_nonzero_index <= result_idx_w;
		end
	end

endmodule

@@ rtl/rdoq_prequant_error_and_last_unit.sv @@
// RDOQ pre-quantization unit: top level joining controller and datapath.
// Depends on rpq_pkg, rpq_in_if/rpq_out_if, rpq_ctrl and rpq_dp.
`timescale 1ns / 1ps

// Takes one signed coefficient word at a time and returns one result word per
// input: the scaled magnitude, the rounded level and the squared uncoded error
// (all zero below the quantizer threshold), plus on the word marked last the
// last significant index of the block (-1 if none). Each word passes through the steps:
// accept, magnitude multiply, level and distortion multiply, squaring, result
// load. The next word is accepted in the cycle after the result load, so the
// unit takes no new word before the last one's result is loaded. A result that
// waits does not hold off the next word's computation, only its retirement.
// Configuration is to be written through the plain write port while the unit
// is idle, which the unit itself does not enforce; writes to an index past the
// last register are ignored.
module rdoq_prequant_error_and_last_unit #(
	parameter int MAX_COEFFS = rpq_pkg::DEF_MAX_COEFFS,
	parameter int ERR_SHIFT  = rpq_pkg::DEF_ERR_SHIFT
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rpq_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rpq_pkg::CFG_DATA_W-1:0] cfg_data,
	rpq_in_if.sink                         coeff,
	rpq_out_if.source                      result
);
	import rpq_pkg::*;

	rpq_cmd_t cmd;

	rpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (coeff.valid),
		.in_ready  (coeff.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cmd       (cmd)
	);

	rpq_dp #(
		.MAX_COEFFS (MAX_COEFFS),
		.ERR_SHIFT  (ERR_SHIFT)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg_wr_en          (cfg_wr_en),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.coefficient        (coeff.coefficient),
		.is_last            (coeff.is_last),
		.scaled_magnitude   (result.scaled_magnitude),
		.level              (result.level),
		.uncoded_error      (result.uncoded_error),
		.block_done         (result.block_done),
		.last_nonzero_index (result.last_nonzero_index)
	);

endmodule

@@ tb/sv/rdoq_prequant_error_and_last_unit_tb.sv @@
// Self-checking testbench for rdoq_prequant_error_and_last_unit: a directed table, then
// random blocks under three idling phases, every result word checked against an in-bench
// predictor or a pinned row. Depends on rpq_pkg, rpq_in_if / rpq_out_if and the unit itself.
`timescale 1ns / 1ps

module rdoq_prequant_error_and_last_unit_tb;
	import rpq_pkg::*;

	localparam int MAX_COEFFS = DEF_MAX_COEFFS;
	localparam int ERR_SHIFT  = DEF_ERR_SHIFT;
	localparam int LIMIT      = 400_000;
	localparam int LONG_HOLD  = 400;

	typedef struct packed {
		logic [WORD_W-1:0]       scaled_magnitude;
		logic [WORD_W-1:0]       level;
		logic [ERR_W-1:0]        uncoded_error;
		logic                    block_done;
		logic signed [IDX_W-1:0] last_nonzero_index;
	} coef_result_t;

	typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

	typedef struct packed {
		row_kind_t                 kind;
		logic [CFG_IDX_W-1:0]      index;
		logic [CFG_DATA_W-1:0]     data;
		logic signed [COEF_W-1:0]  coef;
		logic                      last;
		logic                      pinned;
		coef_result_t              typed;
	} dir_row_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_wr_en;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rpq_in_if  coeff_ch ();
	rpq_out_if result_ch ();

	rdoq_prequant_error_and_last_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.coeff     (coeff_ch),
		.result    (result_ch)
	);

	// Directed table; pinned rows carry a hand-written expectation
	dir_row_t directed_rows [23] = '{
		'{ROW_WORD, '0, '0, 16'sh0000, 1'b1, 1'b1, '{32'd0, 32'd0, 64'd0, 1'b1, -13'sd1}},
		'{ROW_WORD, '0, '0, 16'sd16383, 1'b0, 1'b1, '{32'd0, 32'd0, 64'd0, 1'b0, 13'sd0}},
		'{ROW_WORD, '0, '0, 16'sd16384, 1'b0, 1'b1, '{32'd16384, 32'd1, 64'd0, 1'b0, 13'sd0}},
		'{ROW_WORD, '0, '0, 16'sh7FFF, 1'b0, 1'b1, '{32'd32767, 32'd1, 64'd0, 1'b0, 13'sd0}},
		'{ROW_WORD, '0, '0, 16'sh8000, 1'b1, 1'b1, '{32'd32768, 32'd1, 64'd0, 1'b1, 13'sd3}},
		'{ROW_CFG, CFG_ERROR_SCALE, 32'hFFFF_FFFF, '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_QUANT_SCALE, 32'd65535, '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_QUANT_SHIFT, 32'd30, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh8000, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh0001, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh8001, 1'b1, 1'b0, '0},
		'{ROW_CFG, CFG_QUANT_SHIFT, 32'd0, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh0000, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'shFFFF, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh7FFF, 1'b1, 1'b0, '0},
		'{ROW_CFG, CFG_QUANT_SCALE, 32'd0, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh7FFF, 1'b1, 1'b1, '{32'd0, 32'd0, 64'd0, 1'b1, -13'sd1}},
		'{ROW_CFG, CFG_QUANT_SCALE, 32'd1, '0, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_QUANT_SHIFT, 32'd31, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh8000, 1'b1, 1'b1, '{32'd0, 32'd0, 64'd0, 1'b1, -13'sd1}},
		'{ROW_CFG, CFG_QUANT_SCALE, 32'd65535, '0, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh8000, 1'b0, 1'b0, '0},
		'{ROW_WORD, '0, '0, 16'sh3039, 1'b1, 1'b0, '0}
	};

	// Predictor copy of the registers and derived quantizer constants
	logic [SCALE_W-1:0]    q_scale;
	logic [SHIFT_W-1:0]    q_shift;
	logic [CFG_DATA_W-1:0] e_scale;
	logic [63:0]           round_half;
	logic [63:0]           hit_floor;

	// Predictor copy of the last-position tracker
	logic [11:0]             blk_pos;
	logic signed [IDX_W-1:0] hit_grp_start;
	logic signed [IDX_W-1:0] hit_grp_best;
	logic                    grp_hit;
	logic signed [IDX_W-1:0] grp_best;

	coef_result_t pending_results [$];

	int src_idle_pct;
	int rcv_idle_pct;
	int stall_tick;
	int fails;
	int words_sent;
	int results_checked;
	int blocks_sent;
	int settings_used;

	// Clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("FAILURE");
		$finish;
	end

	function automatic void refresh_threshold();
		round_half = (q_shift == 0) ? 64'd0 : (64'd1 << (q_shift - 1));
		if (q_scale == 0)
			hit_floor = '1;
		else if (round_half == 0)
			hit_floor = 64'd1;
		else
			hit_floor = (round_half - 1) / q_scale + 1;
	endfunction

	function automatic void clear_tracking();
		blk_pos       = '0;
		hit_grp_start = -13'sd1;
		hit_grp_best  = -13'sd1;
		grp_hit       = 1'b0;
		grp_best      = -13'sd1;
	endfunction

	// Quantize one coefficient and advance the last-position tracker
	function automatic coef_result_t quantize_and_track(input logic signed [COEF_W-1:0] c,
			input logic l);
		coef_result_t r;
		logic [MAG_W-1:0] mag;
		logic [63:0] scaled;
		logic [63:0] lvl;
		logic [63:0] err_word;
		r = '0;
		mag = c[COEF_W-1] ? (17'h10000 - {1'b0, c}) : {1'b0, c};
		if (64'(mag) >= hit_floor) begin
			scaled   = 64'(mag) * 64'(q_scale);
			lvl      = ((scaled + round_half) >> q_shift) & 64'hFFFF_FFFF;
			err_word = ((scaled * 64'(e_scale)) >> ERR_SHIFT) & 64'hFFFF_FFFF;
			r.scaled_magnitude = scaled[WORD_W-1:0];
			r.level            = lvl[WORD_W-1:0];
			r.uncoded_error    = err_word * err_word;
			grp_hit = 1'b1;
			if (lvl != 0)
				grp_best = {1'b0, blk_pos};
		end
		// group closes on its 16th word, at the top position, or on the last word
		if (blk_pos % GROUP_SIZE == GROUP_SIZE - 1 || blk_pos == 12'(MAX_COEFFS - 1) || l) begin
			if (grp_hit) begin
				hit_grp_start = 13'(blk_pos - blk_pos % GROUP_SIZE);
				hit_grp_best  = grp_best;
			end
			grp_hit  = 1'b0;
			grp_best = -13'sd1;
		end
		if (l) begin
			r.block_done = 1'b1;
			if (hit_grp_start < 0)
				r.last_nonzero_index = -13'sd1;
			else if (hit_grp_best >= 0)
				r.last_nonzero_index = hit_grp_best;
			else
				r.last_nonzero_index = hit_grp_start;
			clear_tracking();
		end else begin
			blk_pos = blk_pos + 12'd1;
		end
		return r;
	endfunction

	// Coefficient below the current threshold, or one drawn to hit often
	function automatic logic signed [COEF_W-1:0] pick_coef(input bit may_hit);
		int unsigned floor_mag;
		int unsigned m;
		floor_mag = (hit_floor > 64'd32768) ? 32769 : int'(hit_floor);
		if (!may_hit) begin
			m = $urandom_range(floor_mag - 1, 0);
		end else begin
			case ($urandom_range(5, 0))
				0: return 16'($urandom);
				1: m = 32768 - $urandom_range(1, 0);
				2: m = floor_mag - 1 + $urandom_range(2, 0);
				default: m = $urandom_range(2 * floor_mag, 0);
			endcase
		end
		if (m > 32768)
			m = 32768;
		if ($urandom_range(1, 0))
			return 16'(-int'(m));
		return 16'((m > 32767) ? 32767 : m);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		case (idx)
			CFG_QUANT_SCALE: q_scale = val[SCALE_W-1:0];
			CFG_QUANT_SHIFT: q_shift = val[SHIFT_W-1:0];
			CFG_ERROR_SCALE: e_scale = val;
			default: ;
		endcase
		refresh_threshold();
	endtask

	// Offer one word, wait for acceptance, queue its expected result
	task automatic send_word(input logic signed [COEF_W-1:0] c, input logic l,
			input bit pinned = 1'b0, input coef_result_t typed = '0);
		coef_result_t predicted;
		while ($urandom_range(99, 0) < src_idle_pct) begin
			coeff_ch.valid <= 1'b0;
			@(posedge clk);
		end
		coeff_ch.valid       <= 1'b1;
		coeff_ch.coefficient <= c;
		coeff_ch.is_last     <= l;
		@(posedge clk);
		while (!coeff_ch.ready)
			@(posedge clk);
		predicted = quantize_and_track(c, l);
		pending_results.push_back(pinned ? typed : predicted);
		words_sent++;
	endtask

	// Random-content block; each group of 16 draws its own hit density
	task automatic send_block(input int unsigned n_words);
		int unsigned density;
		density = 0;
		for (int unsigned i = 0; i < n_words; i++) begin
			if (i % GROUP_SIZE == 0)
				density = $urandom_range(2, 0);
			send_word(pick_coef(density == 2 || (density == 1 && $urandom_range(3, 0) == 0)),
				i == n_words - 1);
		end
		blocks_sent++;
	endtask

	task automatic drain_results();
		coeff_ch.valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	// Result side pacing, with one long hold-off on request
	always @(posedge clk) begin : rx_pace
		int stall_seen;
		int hold_left;
		if (stall_tick != stall_seen) begin
			stall_seen = stall_tick;
			hold_left  = LONG_HOLD;
		end
		if (hold_left > 0) begin
			hold_left--;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= ($urandom_range(99, 0) >= rcv_idle_pct);
		end
	end

	// Compare each accepted result word with the oldest expectation
	always @(posedge clk) begin : result_check
		coef_result_t got;
		coef_result_t want;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			got = '{result_ch.scaled_magnitude, result_ch.level, result_ch.uncoded_error,
				result_ch.block_done, result_ch.last_nonzero_index};
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result word %h", $time, got);
				fails++;
			end else begin
				want = pending_results.pop_front();
				results_checked++;
				if (got.scaled_magnitude !== want.scaled_magnitude) begin
					$display("%0t: scaled_magnitude expected %0d got %0d", $time,
						want.scaled_magnitude, got.scaled_magnitude);
					fails++;
				end
				if (got.level !== want.level) begin
					$display("%0t: level expected %0d got %0d", $time, want.level, got.level);
					fails++;
				end
				if (got.uncoded_error !== want.uncoded_error) begin
					$display("%0t: uncoded_error expected %0d got %0d", $time,
						want.uncoded_error, got.uncoded_error);
					fails++;
				end
				if (got.block_done !== want.block_done) begin
					$display("%0t: block_done expected %b got %b", $time,
						want.block_done, got.block_done);
					fails++;
				end
				if (got.last_nonzero_index !== want.last_nonzero_index) begin
					$display("%0t: last_nonzero_index expected %0d got %0d", $time,
						want.last_nonzero_index, got.last_nonzero_index);
					fails++;
				end
			end
		end
	end

	// Stimulus
	initial begin
		int seg;
		int unsigned n;
		int unsigned seg_words;
		int unsigned sc;
		int unsigned sh;
		logic [CFG_DATA_W-1:0] es;

		arst_n               = 1'b0;
		cfg_wr_en            = 1'b0;
		cfg_index            = '0;
		cfg_data             = '0;
		coeff_ch.valid       = 1'b0;
		coeff_ch.coefficient = '0;
		coeff_ch.is_last     = 1'b0;
		q_scale              = RST_QUANT_SCALE;
		q_shift              = RST_QUANT_SHIFT;
		e_scale              = RST_ERROR_SCALE;
		refresh_threshold();
		clear_tracking();
		src_idle_pct = 31;
		rcv_idle_pct = 68;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain_results();
				write_reg(directed_rows[i].index, directed_rows[i].data);
			end else begin
				send_word(directed_rows[i].coef, directed_rows[i].last,
					directed_rows[i].pinned, directed_rows[i].typed);
			end
		end

		// random blocks: three segments per idling phase, one setting per segment
		for (seg = 0; seg < 9; seg++) begin
			src_idle_pct = (seg < 3) ? 31 : (seg < 6) ? 68 : 0;
			rcv_idle_pct = (seg < 3) ? 68 : (seg < 6) ? 31 : 0;
			sh = $urandom_range(24, 1);
			sc = $urandom_range(65535, 1) >> $urandom_range(15, 0);
			if (sc == 0)
				sc = 1;
			es = $urandom;
			case (seg)
				0: begin
					sc = 65535;
					sh = 30;
					es = 32'hFFFF_FFFF;
				end
				2: sh = 0;
				4: sc = 0;
				5: begin
					sc = 65535;
					sh = 31;
				end
				7: begin
					sc = 1;
					sh = 1;
					es = '0;
				end
				default: ;
			endcase
			drain_results();
			write_reg(CFG_QUANT_SCALE, 32'(sc));
			write_reg(CFG_QUANT_SHIFT, 32'(sh));
			write_reg(CFG_ERROR_SCALE, es);
			settings_used++;
			// hold the result side off so the unit backs up into its input
			if (seg == 6)
				stall_tick++;
			seg_words = 0;
			while (seg_words < 40) begin
				n = ($urandom_range(5, 0) == 0) ? $urandom_range(40, 1)
					: GROUP_SIZE * $urandom_range(5, 1);
				send_block(n);
				seg_words += n;
			end
		end

		drain_results();
		repeat (10) @(posedge clk);

		$display("Ran %0d words in %0d random blocks plus the directed table over %0d settings,",
			words_sent, blocks_sent, settings_used);
		$display("  %0d result words checked, including a long output hold-off.",
			results_checked);
		if (fails == 0 && pending_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
